// ----- sv/weighted_mf_sgd_update_assert.svh -----
// Assertion macros used by the checker file.
`ifndef WEIGHTED_MF_SGD_UPDATE_ASSERT_SVH
`define WEIGHTED_MF_SGD_UPDATE_ASSERT_SVH

// Same-cycle implication, clocked on i_clk and disabled during reset.
`define WMSU_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk and disabled during reset.
`define WMSU_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- sv/wmsu_pkg.sv -----
package wmsu_pkg;

    localparam int USERS   = 1024;
    localparam int ITEMS   = 1024;
    localparam int FACTORS = 16;

    localparam int UIDX_W     = 10;
    localparam int IIDX_W     = 10;
    localparam int ELEM_W     = 4;
    localparam int DATA_W     = 32;
    localparam int LR_W       = 16;
    localparam int HW_W       = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam int K_W     = (FACTORS > 1) ? $clog2(FACTORS) : 1;
    localparam int UADDR_W = (USERS * FACTORS > 1) ? $clog2(USERS * FACTORS) : 1;
    localparam int IADDR_W = (ITEMS * FACTORS > 1) ? $clog2(ITEMS * FACTORS) : 1;

    localparam logic [LR_W-1:0] RST_LEARN_RATE  = 16'd655;
    localparam logic [LR_W-1:0] RST_USER_REG    = 16'd655;
    localparam logic [LR_W-1:0] RST_ITEM_REG    = 16'd655;
    localparam logic [HW_W-1:0] RST_HEAD_WEIGHT = 17'd52429;

    typedef enum logic [1:0] {
        FN_WR_USER = 2'd0,
        FN_WR_ITEM = 2'd1,
        FN_READ    = 2'd2,
        FN_UPDATE  = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARN_RATE  = 3'd0,
        CFG_USER_REG    = 3'd1,
        CFG_ITEM_REG    = 3'd2,
        CFG_HEAD_WEIGHT = 3'd3,
        CFG_WEIGHT_MODE = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MUL_DOT,
        MUL_HEAD,
        MUL_ERR,
        MUL_REG
    } t_mul_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEC,
        ST_RDAT,
        ST_D_RD,
        ST_D_MUL,
        ST_D_ACC,
        ST_E_SUB,
        ST_E_MUL,
        ST_E_FIN,
        ST_U_RD,
        ST_U_M1,
        ST_U_M2,
        ST_U_M3,
        ST_U_WB,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic           capture;
        logic           rd;
        logic           use_eidx;
        logic [K_W-1:0] k;
        logic           wr_user;
        logic           wr_item;
        logic           wr_input;
        t_mul_sel       mul_sel;
        logic           prod_ld;
        logic           acc_clr;
        logic           acc_add;
        logic           e_ld;
        logic           save_pred;
        logic           err_ld;
        logic           t1_ld;
        logic           step_ld;
        logic           own_item;
        logic           res_rd;
        logic           out_ld;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  urow_ok;
        logic  irow_ok;
        logic  elem_ok;
        logic  from_items;
    } t_status;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] val;
    } t_clamp;

    function automatic logic signed [63:0] round_sh16(input logic signed [63:0] x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    function automatic t_clamp clamp32(input logic signed [63:0] x);
        t_clamp c;
        c.hit = 1'b0;
        c.val = x[DATA_W-1:0];
        if (x > 64'sd2147483647) begin
            c.hit = 1'b1;
            c.val = 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            c.hit = 1'b1;
            c.val = 32'sh80000000;
        end
        return c;
    endfunction

endpackage

// ----- sv/wmsu_ram.sv -----
module wmsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_addr,
    input  logic [WIDTH-1:0]                 i_wdata,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/wmsu_datapath.sv -----
module wmsu_datapath (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [wmsu_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [wmsu_pkg::CFG_DATA_W-1:0]           i_cfg_data,
    input  logic [1:0]                                i_func,
    input  logic [wmsu_pkg::UIDX_W-1:0]               i_user_index,
    input  logic [wmsu_pkg::IIDX_W-1:0]               i_item_index,
    input  logic [wmsu_pkg::ELEM_W-1:0]               i_element_index,
    input  logic signed [wmsu_pkg::DATA_W-1:0]        i_element_value,
    input  logic                                      i_read_from_items,
    input  logic signed [wmsu_pkg::DATA_W-1:0]        i_rating,
    input  logic                                      i_head_item,
    input  logic                                      i_head_user,
    input  wmsu_pkg::t_cmd                            i_cmd,
    output wmsu_pkg::t_status                         o_status,
    output logic signed [wmsu_pkg::DATA_W-1:0]        o_read_value,
    output logic                                      o_saturated
);

    logic [wmsu_pkg::LR_W-1:0] r_learn_rate;
    logic [wmsu_pkg::LR_W-1:0] r_user_reg;
    logic [wmsu_pkg::LR_W-1:0] r_item_reg;
    logic [wmsu_pkg::HW_W-1:0] r_head_weight;
    logic                      r_weight_mode;

    wmsu_pkg::t_func                    r_func;
    logic [wmsu_pkg::UIDX_W-1:0]        r_uidx;
    logic [wmsu_pkg::IIDX_W-1:0]        r_iidx;
    logic [wmsu_pkg::ELEM_W-1:0]        r_eidx;
    logic signed [wmsu_pkg::DATA_W-1:0] r_value;
    logic                               r_from_items;
    logic signed [wmsu_pkg::DATA_W-1:0] r_rating;
    logic                               r_head;

    logic signed [63:0]                 r_prod;
    logic signed [63:0]                 r_acc;
    logic signed [32:0]                 r_e;
    logic signed [wmsu_pkg::DATA_W-1:0] r_err;
    logic signed [47:0]                 r_t1;
    logic signed [64:0]                 r_stepp;
    logic signed [wmsu_pkg::DATA_W-1:0] r_result;
    logic                               r_sat;
    logic signed [wmsu_pkg::DATA_W-1:0] r_o_value;
    logic                               r_o_sat;

    logic [wmsu_pkg::K_W-1:0]           w_elem;
    logic [wmsu_pkg::UADDR_W-1:0]       w_uaddr;
    logic [wmsu_pkg::IADDR_W-1:0]       w_iaddr;
    logic [wmsu_pkg::DATA_W-1:0]        w_wdata;
    logic [wmsu_pkg::DATA_W-1:0]        w_u_rd;
    logic [wmsu_pkg::DATA_W-1:0]        w_i_rd;
    logic signed [wmsu_pkg::DATA_W-1:0] w_own;
    logic signed [wmsu_pkg::DATA_W-1:0] w_other;
    logic signed [32:0]                 w_mul_a;
    logic signed [32:0]                 w_mul_b;
    logic signed [65:0]                 w_prod;
    logic signed [63:0]                 w_prod_rnd;
    wmsu_pkg::t_clamp                   w_acc_cl;
    wmsu_pkg::t_clamp                   w_err_cl;
    logic signed [48:0]                 w_diff;
    logic signed [65:0]                 w_stepp;
    logic signed [65:0]                 w_step;
    logic signed [65:0]                 w_new;
    wmsu_pkg::t_clamp                   w_new_cl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn_rate  <= wmsu_pkg::RST_LEARN_RATE;
            r_user_reg    <= wmsu_pkg::RST_USER_REG;
            r_item_reg    <= wmsu_pkg::RST_ITEM_REG;
            r_head_weight <= wmsu_pkg::RST_HEAD_WEIGHT;
            r_weight_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (wmsu_pkg::t_cfg_idx'(i_cfg_index))
                wmsu_pkg::CFG_LEARN_RATE:  r_learn_rate  <= i_cfg_data[wmsu_pkg::LR_W-1:0];
                wmsu_pkg::CFG_USER_REG:    r_user_reg    <= i_cfg_data[wmsu_pkg::LR_W-1:0];
                wmsu_pkg::CFG_ITEM_REG:    r_item_reg    <= i_cfg_data[wmsu_pkg::LR_W-1:0];
                wmsu_pkg::CFG_HEAD_WEIGHT: r_head_weight <= i_cfg_data[wmsu_pkg::HW_W-1:0];
                wmsu_pkg::CFG_WEIGHT_MODE: r_weight_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_status.func       = r_func;
    assign o_status.urow_ok    = 32'(r_uidx) < 32'(wmsu_pkg::USERS);
    assign o_status.irow_ok    = 32'(r_iidx) < 32'(wmsu_pkg::ITEMS);
    assign o_status.elem_ok    = 32'(r_eidx) < 32'(wmsu_pkg::FACTORS);
    assign o_status.from_items = r_from_items;

    assign w_elem  = i_cmd.use_eidx ? wmsu_pkg::K_W'(r_eidx) : i_cmd.k;
    assign w_uaddr = wmsu_pkg::UADDR_W'(r_uidx) * wmsu_pkg::UADDR_W'(wmsu_pkg::FACTORS)
                   + wmsu_pkg::UADDR_W'(w_elem);
    assign w_iaddr = wmsu_pkg::IADDR_W'(r_iidx) * wmsu_pkg::IADDR_W'(wmsu_pkg::FACTORS)
                   + wmsu_pkg::IADDR_W'(w_elem);
    assign w_wdata = i_cmd.wr_input ? r_value : w_new_cl.val;

    wmsu_ram #(
        .WIDTH(wmsu_pkg::DATA_W),
        .DEPTH(wmsu_pkg::USERS * wmsu_pkg::FACTORS)
    ) u_user_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_user),
        .i_re   (i_cmd.rd),
        .i_addr (w_uaddr),
        .i_wdata(w_wdata),
        .o_rdata(w_u_rd)
    );

    wmsu_ram #(
        .WIDTH(wmsu_pkg::DATA_W),
        .DEPTH(wmsu_pkg::ITEMS * wmsu_pkg::FACTORS)
    ) u_item_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_item),
        .i_re   (i_cmd.rd),
        .i_addr (w_iaddr),
        .i_wdata(w_wdata),
        .o_rdata(w_i_rd)
    );

    assign w_own   = i_cmd.own_item ? $signed(w_i_rd) : $signed(w_u_rd);
    assign w_other = i_cmd.own_item ? $signed(w_u_rd) : $signed(w_i_rd);

    always_comb begin
        case (i_cmd.mul_sel)
            wmsu_pkg::MUL_DOT: begin
                w_mul_a = 33'(w_own);
                w_mul_b = 33'(w_other);
            end
            wmsu_pkg::MUL_HEAD: begin
                w_mul_a = r_e;
                w_mul_b = $signed({16'd0, r_head_weight});
            end
            wmsu_pkg::MUL_ERR: begin
                w_mul_a = 33'(r_err);
                w_mul_b = 33'(w_other);
            end
            wmsu_pkg::MUL_REG: begin
                w_mul_a = $signed({17'd0, (i_cmd.own_item ? r_item_reg : r_user_reg)});
                w_mul_b = 33'(w_own);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod     = w_mul_a * w_mul_b;
    assign w_prod_rnd = wmsu_pkg::round_sh16(r_prod);
    assign w_acc_cl   = wmsu_pkg::clamp32(r_acc);
    assign w_err_cl   = wmsu_pkg::clamp32(r_head ? w_prod_rnd : 64'(r_e));
    assign w_diff     = 49'(r_t1) - 49'(w_prod_rnd);
    assign w_stepp    = $signed({1'b0, r_learn_rate}) * w_diff;
    assign w_step     = (66'(r_stepp) + 66'sd16384) >>> 15;
    assign w_new      = 66'(w_own) + w_step;
    assign w_new_cl   = wmsu_pkg::clamp32(w_new[63:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func       <= wmsu_pkg::t_func'(i_func);
            r_uidx       <= i_user_index;
            r_iidx       <= i_item_index;
            r_eidx       <= i_element_index;
            r_value      <= i_element_value;
            r_from_items <= i_read_from_items;
            r_rating     <= i_rating;
            r_head       <= r_weight_mode ? (i_head_item & i_head_user) : i_head_item;
            r_result     <= '0;
            r_sat        <= 1'b0;
        end
        if (i_cmd.prod_ld) begin
            r_prod <= w_prod[63:0];
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + w_prod_rnd;
        end
        if (i_cmd.e_ld) begin
            r_e <= 33'(r_rating) - 33'(w_acc_cl.val);
        end
        if (i_cmd.save_pred) begin
            r_result <= w_acc_cl.val;
        end
        if (i_cmd.err_ld) begin
            r_err <= w_err_cl.val;
        end
        if (i_cmd.t1_ld) begin
            r_t1 <= w_prod_rnd[47:0];
        end
        if (i_cmd.step_ld) begin
            r_stepp <= w_stepp[64:0];
        end
        if ((i_cmd.wr_user || i_cmd.wr_item) && !i_cmd.wr_input && w_new_cl.hit) begin
            r_sat <= 1'b1;
        end
        if (i_cmd.res_rd) begin
            r_result <= r_from_items ? $signed(w_i_rd) : $signed(w_u_rd);
        end
        if (i_cmd.out_ld) begin
            r_o_value <= r_result;
            r_o_sat   <= r_sat;
        end
    end

    assign o_read_value = r_o_value;
    assign o_saturated  = r_o_sat;

endmodule

// ----- sv/wmsu_ctrl.sv -----
module wmsu_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  wmsu_pkg::t_status   i_status,
    output wmsu_pkg::t_cmd      o_cmd
);

    wmsu_pkg::t_state         r_state;
    wmsu_pkg::t_state         n_state;
    logic [wmsu_pkg::K_W-1:0] r_k;
    logic [wmsu_pkg::K_W-1:0] n_k;
    logic                     r_pass;
    logic                     n_pass;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic                     w_last;

    assign w_last = r_k == wmsu_pkg::K_W'(wmsu_pkg::FACTORS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wmsu_pkg::ST_IDLE;
            r_k         <= '0;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_k            = r_k;
        n_pass         = r_pass;
        n_out_valid    = r_out_valid && i_out_stall;
        o_cmd          = '0;
        o_cmd.mul_sel  = wmsu_pkg::MUL_DOT;
        o_cmd.k        = r_k;
        o_cmd.own_item = r_pass;
        case (r_state)
            wmsu_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = wmsu_pkg::ST_DEC;
                end
            end
            wmsu_pkg::ST_DEC: begin
                o_cmd.use_eidx = 1'b1;
                n_state        = wmsu_pkg::ST_FIN;
                case (i_status.func)
                    wmsu_pkg::FN_WR_USER: begin
                        o_cmd.wr_input = 1'b1;
                        o_cmd.wr_user  = i_status.urow_ok && i_status.elem_ok;
                    end
                    wmsu_pkg::FN_WR_ITEM: begin
                        o_cmd.wr_input = 1'b1;
                        o_cmd.wr_item  = i_status.irow_ok && i_status.elem_ok;
                    end
                    wmsu_pkg::FN_READ: begin
                        if (i_status.elem_ok && (i_status.from_items ? i_status.irow_ok
                                                                     : i_status.urow_ok)) begin
                            o_cmd.rd = 1'b1;
                            n_state  = wmsu_pkg::ST_RDAT;
                        end
                    end
                    wmsu_pkg::FN_UPDATE: begin
                        if (i_status.urow_ok && i_status.irow_ok) begin
                            n_k     = '0;
                            n_pass  = 1'b0;
                            n_state = wmsu_pkg::ST_D_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            wmsu_pkg::ST_RDAT: begin
                o_cmd.res_rd = 1'b1;
                n_state      = wmsu_pkg::ST_FIN;
            end
            wmsu_pkg::ST_D_RD: begin
                o_cmd.rd      = 1'b1;
                o_cmd.acc_clr = r_k == '0;
                n_state       = wmsu_pkg::ST_D_MUL;
            end
            wmsu_pkg::ST_D_MUL: begin
                o_cmd.mul_sel = wmsu_pkg::MUL_DOT;
                o_cmd.prod_ld = 1'b1;
                n_state       = wmsu_pkg::ST_D_ACC;
            end
            wmsu_pkg::ST_D_ACC: begin
                o_cmd.acc_add = 1'b1;
                if (w_last) begin
                    n_k     = '0;
                    n_state = wmsu_pkg::ST_E_SUB;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = wmsu_pkg::ST_D_RD;
                end
            end
            wmsu_pkg::ST_E_SUB: begin
                o_cmd.e_ld      = 1'b1;
                o_cmd.save_pred = !r_pass;
                n_state         = wmsu_pkg::ST_E_MUL;
            end
            wmsu_pkg::ST_E_MUL: begin
                o_cmd.mul_sel = wmsu_pkg::MUL_HEAD;
                o_cmd.prod_ld = 1'b1;
                n_state       = wmsu_pkg::ST_E_FIN;
            end
            wmsu_pkg::ST_E_FIN: begin
                o_cmd.err_ld = 1'b1;
                n_state      = wmsu_pkg::ST_U_RD;
            end
            wmsu_pkg::ST_U_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = wmsu_pkg::ST_U_M1;
            end
            wmsu_pkg::ST_U_M1: begin
                o_cmd.mul_sel = wmsu_pkg::MUL_ERR;
                o_cmd.prod_ld = 1'b1;
                n_state       = wmsu_pkg::ST_U_M2;
            end
            wmsu_pkg::ST_U_M2: begin
                o_cmd.t1_ld   = 1'b1;
                o_cmd.mul_sel = wmsu_pkg::MUL_REG;
                o_cmd.prod_ld = 1'b1;
                n_state       = wmsu_pkg::ST_U_M3;
            end
            wmsu_pkg::ST_U_M3: begin
                o_cmd.step_ld = 1'b1;
                n_state       = wmsu_pkg::ST_U_WB;
            end
            wmsu_pkg::ST_U_WB: begin
                o_cmd.wr_user = !r_pass;
                o_cmd.wr_item = r_pass;
                if (w_last) begin
                    n_k = '0;
                    if (r_pass) begin
                        n_state = wmsu_pkg::ST_FIN;
                    end else begin
                        n_pass  = 1'b1;
                        n_state = wmsu_pkg::ST_D_RD;
                    end
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = wmsu_pkg::ST_U_RD;
                end
            end
            wmsu_pkg::ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_ld = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = wmsu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wmsu_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = r_state != wmsu_pkg::ST_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

// ----- sv/weighted_mf_sgd_update.sv -----
// Fixed-point weighted SGD engine for matrix factorisation: it holds user and item factor
// tables in single-port RAMs and handles one transaction at a time. An update runs two dot
// products, two error steps and two row updates; the products and error terms share one
// multiplier fed by registered table reads, and a second multiplier scales each step by the
// learning rate. A stalled output holds a transaction in its final state until the result
// register is free. A finished result sits in an output register, so the next transaction
// can be accepted while it waits to be taken.
module weighted_mf_sgd_update (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wmsu_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wmsu_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_func,
    input  logic [wmsu_pkg::UIDX_W-1:0]         i_user_index,
    input  logic [wmsu_pkg::IIDX_W-1:0]         i_item_index,
    input  logic [wmsu_pkg::ELEM_W-1:0]         i_element_index,
    input  logic signed [wmsu_pkg::DATA_W-1:0]  i_element_value,
    input  logic                                i_read_from_items,
    input  logic signed [wmsu_pkg::DATA_W-1:0]  i_rating,
    input  logic                                i_head_item,
    input  logic                                i_head_user,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [wmsu_pkg::DATA_W-1:0]  o_read_value,
    output logic                                o_saturated
);

    wmsu_pkg::t_cmd    w_cmd;
    wmsu_pkg::t_status w_status;

    wmsu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    wmsu_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_func           (i_func),
        .i_user_index     (i_user_index),
        .i_item_index     (i_item_index),
        .i_element_index  (i_element_index),
        .i_element_value  (i_element_value),
        .i_read_from_items(i_read_from_items),
        .i_rating         (i_rating),
        .i_head_item      (i_head_item),
        .i_head_user      (i_head_user),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_read_value     (o_read_value),
        .o_saturated      (o_saturated)
    );

endmodule

// ----- sv/wmsu_checker.sv -----
`include "weighted_mf_sgd_update_assert.svh"

module wmsu_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [wmsu_pkg::DATA_W-1:0]  o_read_value,
    input logic                                o_saturated
);

    `WMSU_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")
    `WMSU_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_read_value) && $stable(o_saturated), "stalled result changed")
    `WMSU_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "input not stalled after a transaction was accepted")
    `WMSU_ASSERT_NOW(a_result_from_busy, $rose(o_out_valid), $past(o_in_stall), "result appeared without a transaction in progress")

endmodule

bind weighted_mf_sgd_update wmsu_checker u_wmsu_checker (.*);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import wmsu_pkg::*;

    typedef struct {
        t_func              func;
        logic [UIDX_W-1:0]  uidx;
        logic [IIDX_W-1:0]  iidx;
        logic [ELEM_W-1:0]  eidx;
        logic signed [31:0] value;
        logic               from_items;
        logic signed [31:0] rating;
        logic               hi;
        logic               hu;
    } op_t;

    typedef struct {
        logic signed [31:0] val;
        logic               sat;
    } res_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [1:0] i_func = '0;
    logic [UIDX_W-1:0] i_user_index = '0;
    logic [IIDX_W-1:0] i_item_index = '0;
    logic [ELEM_W-1:0] i_element_index = '0;
    logic signed [DATA_W-1:0] i_element_value = '0;
    logic i_read_from_items = 1'b0;
    logic signed [DATA_W-1:0] i_rating = '0;
    logic i_head_item = 1'b0;
    logic i_head_user = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_read_value;
    logic o_saturated;

    weighted_mf_sgd_update uut (.*);

    always #5 i_clk = ~i_clk;

    int user_tab [USERS*FACTORS];
    int item_tab [ITEMS*FACTORS];
    bit user_wr [USERS*FACTORS];
    bit item_wr [ITEMS*FACTORS];
    longint lr_q, ureg_q, ireg_q, hw_q;
    bit mode_q;

    op_t  op_queue [$];
    res_t result_queue [$];
    int   mismatches = 0;
    bit   failed = 0;
    logic [UIDX_W-1:0] user_pool [8];
    logic [IIDX_W-1:0] item_pool [8];

    function automatic longint rnd_sh(longint x, int n);
        return (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint sat32(longint x, inout bit hit);
        if (x > 64'sd2147483647) begin
            hit = 1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            hit = 1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    function automatic longint dot_rows(input int a [FACTORS], input int b [FACTORS]);
        longint acc = 0;
        bit dummy = 0;
        for (int k = 0; k < FACTORS; k++) acc += rnd_sh(longint'(a[k]) * b[k], 16);
        return sat32(acc, dummy);
    endfunction

    function automatic longint head_err(longint rating, longint pred, bit head);
        longint e = rating - pred;
        bit dummy = 0;
        if (head) e = rnd_sh(e * hw_q, 16);
        return sat32(e, dummy);
    endfunction

    function automatic void sgd_row(inout int row [FACTORS], input int oth [FACTORS],
                                    input longint err, input longint rg, inout bit hit);
        longint t1, t2, st;
        for (int k = 0; k < FACTORS; k++) begin
            t1 = rnd_sh(err * oth[k], 16);
            t2 = rnd_sh(rg * row[k], 16);
            st = rnd_sh(lr_q * (t1 - t2), 15);
            row[k] = int'(sat32(longint'(row[k]) + st, hit));
        end
    endfunction

    function automatic res_t apply_op(op_t op);
        res_t r;
        int ur [FACTORS];
        int ir [FACTORS];
        int ub, ib;
        bit head;
        longint pred, err;
        r.val = 0;
        r.sat = 0;
        ub = int'(op.uidx) * FACTORS;
        ib = int'(op.iidx) * FACTORS;
        case (op.func)
            FN_WR_USER: begin
                user_tab[ub + op.eidx] = op.value;
                user_wr[ub + op.eidx] = 1;
            end
            FN_WR_ITEM: begin
                item_tab[ib + op.eidx] = op.value;
                item_wr[ib + op.eidx] = 1;
            end
            FN_READ: r.val = op.from_items ? item_tab[ib + op.eidx] : user_tab[ub + op.eidx];
            default: begin
                bit hit = 0;
                for (int k = 0; k < FACTORS; k++) begin
                    ur[k] = user_tab[ub + k];
                    ir[k] = item_tab[ib + k];
                end
                head = mode_q ? (op.hi && op.hu) : op.hi;
                pred = dot_rows(ur, ir);
                r.val = pred[31:0];
                err = head_err(op.rating, pred, head);
                sgd_row(ur, ir, err, ureg_q, hit);
                err = head_err(op.rating, dot_rows(ur, ir), head);
                sgd_row(ir, ur, err, ireg_q, hit);
                for (int k = 0; k < FACTORS; k++) begin
                    user_tab[ub + k] = ur[k];
                    item_tab[ib + k] = ir[k];
                end
                r.sat = hit;
            end
        endcase
        return r;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    op_t cur;
    int  burst_left = 0;
    int  gap_left = 0;
    always @(posedge i_clk) begin
        bit busy;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            busy = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                result_queue.push_back(apply_op(cur));
                busy = 0;
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (op_queue.size() > 0) begin
                    cur = op_queue.pop_front();
                    i_func <= cur.func;
                    i_user_index <= cur.uidx;
                    i_item_index <= cur.iidx;
                    i_element_index <= cur.eidx;
                    i_element_value <= cur.value;
                    i_read_from_items <= cur.from_items;
                    i_rating <= cur.rating;
                    i_head_item <= cur.hi;
                    i_head_user <= cur.hu;
                    i_in_valid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stalls in random windows, with quiet stretches in between.
    int stall_cnt = 0;
    always @(posedge i_clk) begin
        stall_cnt++;
        if (stall_cnt[9:8] == 2'd0) i_out_stall <= 1'b0;
        else if (stall_cnt[9:8] == 2'd3) i_out_stall <= ($urandom_range(0, 1) == 0);
        else i_out_stall <= ($urandom_range(0, 4) == 0);
    end

    always @(posedge i_clk) begin
        res_t e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (result_queue.size() == 0) begin
                failed = 1;
                mismatches++;
                if (mismatches <= 10) $display("Unexpected transaction: value %0d sat %0b",
                                               o_read_value, o_saturated);
            end else begin
                e = result_queue.pop_front();
                if (o_read_value !== e.val || o_saturated !== e.sat) begin
                    failed = 1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: value exp %0d got %0d, sat exp %0b got %0b",
                                 e.val, o_read_value, e.sat, o_saturated);
                end
            end
        end
    end

    function automatic int small_val();
        return int'($urandom_range(0, 262144)) - 131072;
    endfunction

    function automatic op_t mk(t_func f, int u, int it, int el, int v, bit fi, int rt,
                               bit hi, bit hu);
        op_t o;
        o.func = f;
        o.uidx = u;
        o.iidx = it;
        o.eidx = el;
        o.value = v;
        o.from_items = fi;
        o.rating = rt;
        o.hi = hi;
        o.hu = hu;
        return o;
    endfunction

    function automatic op_t random_op();
        int sel = $urandom_range(0, 99);
        int u = user_pool[$urandom_range(0, 7)];
        int it = item_pool[$urandom_range(0, 7)];
        int el = $urandom_range(0, FACTORS - 1);
        int v = ($urandom_range(0, 9) == 0) ? int'($urandom) : small_val();
        int rt = ($urandom_range(0, 19) == 0) ? int'($urandom)
                 : int'($urandom_range(0, 655360)) - 327680;
        int idx;
        op_t o = mk(FN_UPDATE, u, it, el, $urandom, $urandom, rt, $urandom, $urandom);
        if (sel < 10) begin
            o = mk(t_func'($urandom_range(0, 1)), $urandom, $urandom, el, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
        end else if (sel < 25) begin
            o.func = t_func'($urandom_range(0, 1));
            o.value = v;
        end else if (sel < 40) begin
            o.func = FN_READ;
            o.uidx = $urandom;
            o.iidx = $urandom;
            idx = o.from_items ? int'(o.iidx) * FACTORS + el : int'(o.uidx) * FACTORS + el;
            if (!(o.from_items ? item_wr[idx] : user_wr[idx])) begin
                o.uidx = u;
                o.iidx = it;
            end
        end
        return o;
    endfunction

    task automatic cfg_write(t_cfg_idx idx, int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_LEARN_RATE:  lr_q = val & 16'hffff;
            CFG_USER_REG:    ureg_q = val & 16'hffff;
            CFG_ITEM_REG:    ireg_q = val & 16'hffff;
            CFG_HEAD_WEIGHT: hw_q = val & 17'h1ffff;
            default:         mode_q = val[0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (op_queue.size() > 0 || i_in_valid || result_queue.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_cfg(int lr, int ur, int ir, int hw, int md);
        drain();
        cfg_write(CFG_LEARN_RATE, lr);
        cfg_write(CFG_USER_REG, ur);
        cfg_write(CFG_ITEM_REG, ir);
        cfg_write(CFG_HEAD_WEIGHT, hw);
        cfg_write(CFG_WEIGHT_MODE, md);
    endtask

    initial begin
        lr_q = RST_LEARN_RATE;
        ureg_q = RST_USER_REG;
        ireg_q = RST_ITEM_REG;
        hw_q = RST_HEAD_WEIGHT;
        mode_q = 0;
        user_pool[0] = 0;
        user_pool[1] = USERS - 1;
        item_pool[0] = 0;
        item_pool[1] = ITEMS - 1;
        for (int p = 2; p < 8; p++) begin
            user_pool[p] = $urandom;
            item_pool[p] = $urandom;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < 8; p++)
            for (int k = 0; k < FACTORS; k++) begin
                op_queue.push_back(mk(FN_WR_USER, user_pool[p], 0, k, small_val(), 0, 0, 0, 0));
                op_queue.push_back(mk(FN_WR_ITEM, 0, item_pool[p], k, small_val(), 0, 0, 0, 0));
            end
        op_queue.push_back(mk(FN_WR_USER, 1023, 1023, 15, 32'h7fffffff, 1, 0, 1, 1));
        op_queue.push_back(mk(FN_WR_ITEM, 1023, 1023, 15, 32'h80000000, 0, 0, 1, 1));
        op_queue.push_back(mk(FN_READ, 1023, 1023, 15, 0, 0, 0, 0, 0));
        op_queue.push_back(mk(FN_READ, 1023, 1023, 15, -1, 1, -1, 1, 1));
        op_queue.push_back(mk(FN_READ, 0, 0, 0, 0, 1, 0, 0, 0));
        op_queue.push_back(mk(FN_UPDATE, 0, 0, 0, 0, 0, 65536, 0, 0));
        op_queue.push_back(mk(FN_UPDATE, 0, 0, 0, 0, 0, 65536, 1, 0));
        op_queue.push_back(mk(FN_UPDATE, 0, 0, 0, 0, 0, 65536, 0, 1));
        op_queue.push_back(mk(FN_UPDATE, 0, 0, 0, 0, 0, 65536, 1, 1));
        op_queue.push_back(mk(FN_UPDATE, 1023, 1023, 0, 0, 0, 32'h7fffffff, 1, 1));
        op_queue.push_back(mk(FN_UPDATE, 1023, 1023, 0, 0, 0, 32'h80000000, 0, 0));
        op_queue.push_back(mk(FN_READ, 1023, 1023, 15, 0, 0, 0, 0, 0));
        op_queue.push_back(mk(FN_READ, 1023, 1023, 14, 0, 1, 0, 0, 0));
        for (int k = 0; k < FACTORS; k++) begin
            op_queue.push_back(mk(FN_WR_USER, 1023, 0, k, small_val(), 0, 0, 0, 0));
            op_queue.push_back(mk(FN_WR_ITEM, 0, 1023, k, small_val(), 0, 0, 0, 0));
        end
        repeat (200) op_queue.push_back(random_op());

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: set_cfg(65535, 0, 65535, 65536, 1);
                1: set_cfg(0, 65535, 0, 0, 0);
                2: set_cfg(6554, 3277, 3277, 131071, 1);
                3: set_cfg(1, 1, 1, 32768, 0);
                4: set_cfg(32768, 65535, 65535, 65535, 1);
                default: set_cfg($urandom_range(0, 8000), $urandom_range(0, 65535),
                                 $urandom_range(0, 65535), $urandom_range(0, 65536),
                                 $urandom_range(0, 1));
            endcase
            repeat (180) op_queue.push_back(random_op());
        end

        drain();
        repeat (300) @(posedge i_clk);
        if (result_queue.size() != 0) failed = 1;
        if (!failed) begin
            $display("weighted_mf_sgd_update verification clean");
        end else begin
            $display("weighted_mf_sgd_update verification failed");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("weighted_mf_sgd_update verification failed");
        $finish;
    end
endmodule
